// ===== rtl/core/esp_pkg.sv =====
package esp_pkg;

	localparam int WHEELS_DEF    = 4;
	localparam int SUM_WIDTH_DEF = 48;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int MUL_W      = 32;

	localparam logic [31:0] SPEED_K = 32'd3932160000;
	localparam logic [63:0] SAT64   = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [31:0] RST_TARGET  = 32'd55706;
	localparam logic [15:0] RST_GAIN_P  = 16'd8960;
	localparam logic [15:0] RST_GAIN_I  = 16'd8960;
	localparam logic [15:0] RST_GAIN_D  = 16'd2560;
	localparam logic [15:0] RST_CPR     = 16'd1560;
	localparam logic [15:0] RST_PWM_MAX = 16'd999;

	typedef enum logic [2:0] {
		REG_TARGET,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_CPR,
		REG_PWM_MAX
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_speed;
		logic [15:0]        gain_p;
		logic [15:0]        gain_i;
		logic [15:0]        gain_d;
		logic [15:0]        counts_per_rev;
		logic [15:0]        pwm_max;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MUL_K,
		ST_MUL_DIV,
		ST_DIV_CHK,
		ST_DIV,
		ST_SPEED,
		ST_ERR,
		ST_PLO,
		ST_PHI,
		ST_PSUM,
		ST_ACC,
		ST_DRIVE
	} st_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

endpackage

// ===== rtl/core/esp_mul.sv =====
module esp_mul (
	input  logic                            clk,
	input  logic [esp_pkg::MUL_W-1:0]       a,
	input  logic [esp_pkg::MUL_W-1:0]       b,
	output logic [2*esp_pkg::MUL_W-1:0]     p_q
);
	import esp_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/core/esp_apb.sv =====
module esp_apb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [esp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [esp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [esp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output esp_pkg::cfg_t                    cfg
);
	import esp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed   <= RST_TARGET;
			cfg_q.gain_p         <= RST_GAIN_P;
			cfg_q.gain_i         <= RST_GAIN_I;
			cfg_q.gain_d         <= RST_GAIN_D;
			cfg_q.counts_per_rev <= RST_CPR;
			cfg_q.pwm_max        <= RST_PWM_MAX;
		end else if (wr) begin
			case (idx)
				REG_TARGET:  cfg_q.target_speed   <= pwdata[31:0];
				REG_GAIN_P:  cfg_q.gain_p         <= pwdata[15:0];
				REG_GAIN_I:  cfg_q.gain_i         <= pwdata[15:0];
				REG_GAIN_D:  cfg_q.gain_d         <= pwdata[15:0];
				REG_CPR:     cfg_q.counts_per_rev <= pwdata[15:0];
				REG_PWM_MAX: cfg_q.pwm_max        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TARGET:  prdata = cfg_q.target_speed;
			REG_GAIN_P:  prdata = {16'd0, cfg_q.gain_p};
			REG_GAIN_I:  prdata = {16'd0, cfg_q.gain_i};
			REG_GAIN_D:  prdata = {16'd0, cfg_q.gain_d};
			REG_CPR:     prdata = {16'd0, cfg_q.counts_per_rev};
			REG_PWM_MAX: prdata = {16'd0, cfg_q.pwm_max};
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/encoder_speed_pid_top.sv =====
// Per-wheel encoder speed measurement with a positional PID loop.
// Input stream (s_*): one sample per transfer; tdata carries count and elapsed_ms,
// tuser carries the wheel index and the reversed-wiring flag. Samples for a wheel
// index at or above WHEELS are dropped without a result.
// Output stream (m_*): one result per sample; tdata carries speed (Q16.16 rpm) and
// drive, tuser carries wheel_out, clamped and time_error.
// APB port: six registers at byte addresses 0,4,..,20 (target_speed, gain_p, gain_i,
// gain_d, counts_per_rev, pwm_max); write only while no sample is in flight.
// Steps: after the input transfer a sample passes delta, the speed and divisor products,
// the 32-step restoring divider, speed, error and the P, I and D terms, then drive; a
// saturating speed quotient skips the divider and a zero elapsed_ms skips the speed
// path. s_tready is high only in idle, entered as the result is loaded, so no new sample
// is taken while one is in flight; the shared 32x32 multiplier is passed eight times.
// The result sits in an output register; when the receiver stalls, a finished
// result waits there and the next sample is worked until its own result is ready.
// Reset clears per-wheel count, error and error sum, and loads register defaults.
module encoder_speed_pid_top #(
	parameter int WHEELS    = esp_pkg::WHEELS_DEF,
	parameter int SUM_WIDTH = esp_pkg::SUM_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [47:0]                      s_tdata,  // count[31:0], elapsed_ms[47:32]
	input  logic [2:0]                       s_tuser,  // wheel[1:0], reversed[2]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [47:0]                      m_tdata,  // speed[31:0], drive[47:32]
	output logic [3:0]                       m_tuser,  // wheel_out[1:0], clamped[2], time_error[3]
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [esp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [esp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [esp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import esp_pkg::*;

	localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam logic signed [65:0] SUM_HI = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] SUM_LO = (SUM_WIDTH >= 64) ? -SUM_HI : -SUM_HI - 66'sd1;
	localparam logic signed [64:0] ACC_HI = $signed({1'b0, SAT64});
	localparam logic signed [64:0] ACC_LO = -ACC_HI;

	cfg_t cfg;
	st_t  state_q, state_d;

	logic [31:0]                  lastc_q [WHEELS];
	logic signed [31:0]           laste_q [WHEELS];
	logic signed [SUM_WIDTH-1:0]  esum_q  [WHEELS];

	logic [1:0]               wheel_q;
	logic [31:0]              cnt_q;
	logic [15:0]              ms_q;
	logic                     rev_q;
	logic [IDX_W-1:0]         widx;

	logic [31:0]              mag_q;
	logic                     dneg_q;
	logic                     terr_q;
	logic [63:0]              dvd_q;
	logic [31:0]              div_q;
	logic [31:0]              rem_q;
	logic [4:0]               dcnt_q;
	logic                     ovf_q;
	logic signed [31:0]       speed_q;
	logic signed [31:0]       err_q;
	logic signed [32:0]       deriv_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	term_t                    term_q;
	logic                     pneg_q;
	logic [47:0]              pl_q;
	logic signed [63:0]       tv_q;
	logic signed [63:0]       acc_q;

	logic                     m_tvalid_q;
	logic [31:0]              o_speed_q;
	logic [15:0]              o_drive_q;
	logic [1:0]               o_wheel_q;
	logic                     o_clamped_q;
	logic                     o_terr_q;

	logic [31:0]              mul_a, mul_b;
	logic [63:0]              prod_q;

	logic                     wheel_ok;
	logic                     take_in;
	logic                     out_free;

	logic [31:0]              du;
	logic signed [32:0]       d33;
	logic                     dneg;
	logic [31:0]              dmag;
	logic [15:0]              cpr_eff;
	logic                     div_ovf;
	logic [32:0]              rstep;
	logic                     rge;
	logic [31:0]              rnext;
	logic [31:0]              quo;
	logic signed [31:0]       speed_sat;
	logic signed [32:0]       e33;
	logic signed [31:0]       err_sat;
	logic signed [65:0]       s66;
	logic signed [65:0]       s_clamp;
	logic signed [63:0]       op;
	logic [15:0]              gain;
	logic                     opneg;
	logic [63:0]              opmag;
	logic [80:0]              pfull;
	logic [63:0]              psat;
	logic signed [64:0]       a65;
	logic signed [63:0]       acc_sat;
	logic [39:0]              qd;
	logic [15:0]              drive_v;
	logic                     clamp_v;

	esp_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	esp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign widx     = IDX_W'(wheel_q);
	assign wheel_ok = 32'(s_tuser[1:0]) < WHEELS;
	assign s_tready = (state_q == ST_IDLE);
	assign take_in  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {o_drive_q, o_speed_q};
	assign m_tuser  = {o_terr_q, o_clamped_q, o_wheel_q};

	// count delta with modular wrap
	always_comb begin
		du   = cnt_q - lastc_q[widx];
		d33  = rev_q ? -33'($signed(du)) : 33'($signed(du));
		dneg = d33[32];
		dmag = dneg ? 32'(-d33) : d33[31:0];
	end

	assign cpr_eff = (cfg.counts_per_rev == 16'd0) ? 16'd1 : cfg.counts_per_rev;
	assign div_ovf = dvd_q[63:32] >= prod_q[31:0];

	// restoring divider step
	always_comb begin
		rstep = {rem_q, dvd_q[31]};
		rge   = rstep >= {1'b0, div_q};
		rnext = rge ? 32'(rstep - {1'b0, div_q}) : rstep[31:0];
	end

	always_comb begin
		quo = dvd_q[31:0];
		if (!dneg_q) begin
			speed_sat = (ovf_q || quo[31]) ? 32'sh7FFF_FFFF : $signed(quo);
		end else begin
			speed_sat = (ovf_q || quo[31]) ? 32'sh8000_0000 : -$signed(quo);
		end
	end

	always_comb begin
		e33 = 33'(cfg.target_speed) - 33'(speed_q);
		if (e33[32] != e33[31]) begin
			err_sat = e33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			err_sat = e33[31:0];
		end
		s66 = 66'(esum_q[widx]) + 66'(err_sat);
		if (s66 > SUM_HI) begin
			s_clamp = SUM_HI;
		end else if (s66 < SUM_LO) begin
			s_clamp = SUM_LO;
		end else begin
			s_clamp = s66;
		end
	end

	// PID operand select
	always_comb begin
		case (term_q)
			TERM_P: begin
				op   = 64'(err_q);
				gain = cfg.gain_p;
			end
			TERM_I: begin
				op   = 64'(sum_q);
				gain = cfg.gain_i;
			end
			TERM_D: begin
				op   = 64'(deriv_q);
				gain = cfg.gain_d;
			end
			default: begin
				op   = '0;
				gain = '0;
			end
		endcase
		opneg = op[63];
		opmag = opneg ? 64'(-op) : 64'(op);
	end

	always_comb begin
		pfull = 81'(pl_q) + {prod_q[48:0], 32'd0};
		psat  = (pfull > 81'(SAT64)) ? SAT64 : pfull[63:0];
		a65   = 65'(acc_q) + 65'(tv_q);
		if (a65 > ACC_HI) begin
			acc_sat = SAT64;
		end else if (a65 < ACC_LO) begin
			acc_sat = -$signed(SAT64);
		end else begin
			acc_sat = a65[63:0];
		end
		qd = acc_q[63:24];
		if (acc_q[63]) begin
			drive_v = 16'd0;
			clamp_v = 1'b1;
		end else if (qd > 40'(cfg.pwm_max)) begin
			drive_v = cfg.pwm_max;
			clamp_v = 1'b1;
		end else begin
			drive_v = qd[15:0];
			clamp_v = 1'b0;
		end
	end

	always_comb begin
		case (state_q)
			ST_MUL_K: begin
				mul_a = mag_q;
				mul_b = SPEED_K;
			end
			ST_MUL_DIV: begin
				mul_a = 32'(cpr_eff);
				mul_b = 32'(ms_q);
			end
			ST_PLO: begin
				mul_a = opmag[31:0];
				mul_b = 32'(gain);
			end
			ST_PHI: begin
				mul_a = opmag[63:32];
				mul_b = 32'(gain);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (take_in && wheel_ok) state_d = ST_DELTA;
			ST_DELTA:   state_d = (ms_q == 16'd0) ? ST_ERR : ST_MUL_K;
			ST_MUL_K:   state_d = ST_MUL_DIV;
			ST_MUL_DIV: state_d = ST_DIV_CHK;
			ST_DIV_CHK: state_d = div_ovf ? ST_SPEED : ST_DIV;
			ST_DIV:     if (dcnt_q == 5'd0) state_d = ST_SPEED;
			ST_SPEED:   state_d = ST_ERR;
			ST_ERR:     state_d = ST_PLO;
			ST_PLO:     state_d = ST_PHI;
			ST_PHI:     state_d = ST_PSUM;
			ST_PSUM:    state_d = ST_ACC;
			ST_ACC:     state_d = (term_q == TERM_D) ? ST_DRIVE : ST_PLO;
			ST_DRIVE:   if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WHEELS; k++) begin
				lastc_q[k] <= '0;
				laste_q[k] <= '0;
				esum_q[k]  <= '0;
			end
			m_tvalid_q <= 1'b0;
			term_q     <= TERM_P;
			dcnt_q     <= '0;
		end else begin
			case (state_q)
				ST_DIV_CHK: dcnt_q <= 5'd31;
				ST_DIV:     dcnt_q <= dcnt_q - 5'd1;
				ST_ERR: begin
					lastc_q[widx] <= cnt_q;
					laste_q[widx] <= err_sat;
					esum_q[widx]  <= SUM_WIDTH'(s_clamp);
					term_q        <= TERM_P;
				end
				ST_ACC: if (term_q != TERM_D) term_q <= term_t'(term_q + 2'd1);
				default: ;
			endcase
			if (state_q == ST_DRIVE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					wheel_q <= s_tuser[1:0];
					rev_q   <= s_tuser[2];
					cnt_q   <= s_tdata[31:0];
					ms_q    <= s_tdata[47:32];
				end
			end
			ST_DELTA: begin
				mag_q   <= dmag;
				dneg_q  <= dneg;
				terr_q  <= (ms_q == 16'd0);
				speed_q <= '0;
			end
			ST_MUL_DIV: dvd_q <= prod_q;
			ST_DIV_CHK: begin
				div_q <= prod_q[31:0];
				ovf_q <= div_ovf;
				rem_q <= dvd_q[63:32];
			end
			ST_DIV: begin
				rem_q <= rnext;
				dvd_q <= {dvd_q[62:0], rge};
			end
			ST_SPEED: speed_q <= speed_sat;
			ST_ERR: begin
				err_q   <= err_sat;
				deriv_q <= 33'(err_sat) - 33'(laste_q[widx]);
				sum_q   <= SUM_WIDTH'(s_clamp);
				acc_q   <= '0;
			end
			ST_PLO:  pneg_q <= opneg;
			ST_PHI:  pl_q   <= prod_q[47:0];
			ST_PSUM: tv_q   <= pneg_q ? -$signed(psat) : $signed(psat);
			ST_ACC:  acc_q  <= acc_sat;
			ST_DRIVE: begin
				if (out_free) begin
					o_speed_q   <= speed_q;
					o_drive_q   <= drive_v;
					o_wheel_q   <= wheel_q;
					o_clamped_q <= clamp_v;
					o_terr_q    <= terr_q;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tdata[31:0] == 32'd0)
		else $error("time error result with nonzero speed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:32] <= cfg.pwm_max)
		else $error("drive above pwm_max");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DRIVE)
		else $error("result raised outside drive step");

endmodule

// ===== bench/speed_pid_checker.sv =====
module speed_pid_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // count[31:0], elapsed_ms[47:32]
	input  logic [2:0]                     s_tuser,  // wheel[1:0], reversed[2]
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [47:0]                    m_tdata,  // speed[31:0], drive[47:32]
	input  logic [3:0]                     m_tuser,  // wheel_out[1:0], clamped[2], time_error[3]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [esp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [esp_pkg::APB_DATA_W-1:0] pwdata,
	output int                             fail_count,
	output int                             outstanding
);
	import esp_pkg::*;

	localparam int NW = WHEELS_DEF;
	localparam int SW = SUM_WIDTH_DEF;

	typedef logic signed [127:0] wide_t;

	localparam wide_t SAT     = $signed({64'd0, SAT64});
	localparam wide_t SUM_MAX = (128'sd1 <<< (SW - 1)) - 128'sd1;
	localparam wide_t SUM_MIN = -SUM_MAX - 128'sd1;
	localparam wide_t I32_MAX = 128'sd2147483647;
	localparam wide_t I32_MIN = -128'sd2147483648;

	typedef struct packed {
		logic [1:0]         wheel;
		logic signed [31:0] speed;
		logic [15:0]        drive;
		logic               clamped;
		logic               time_err;
	} wheel_result_t;

	cfg_t               cfg;
	logic [31:0]        prev_count [NW];
	logic signed [31:0] prev_err   [NW];
	logic signed [63:0] err_acc    [NW];
	wheel_result_t      wheel_results [$];

	function automatic wide_t clip(input wide_t v, input wide_t lo, input wide_t hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic wide_t scale_gain(input wide_t v, input logic [15:0] g);
		wide_t mag;
		wide_t p;
		mag = (v < 0) ? -v : v;
		p = mag * $signed({112'd0, g});
		if (p > SAT)
			p = SAT;
		return (v < 0) ? -p : p;
	endfunction

	function automatic wheel_result_t pid_step(input logic [1:0] w, input logic [31:0] cnt,
			input logic [15:0] ms, input logic rev);
		wheel_result_t      r;
		logic [31:0]        du;
		logic [15:0]        cpr_eff;
		logic [63:0]        den;
		wide_t              delta;
		wide_t              mag;
		wide_t              q;
		wide_t              err;
		wide_t              deriv;
		wide_t              sum;
		wide_t              acc;
		logic signed [31:0] spd;
		spd = 32'sd0;
		if (ms != 16'd0) begin
			du = cnt - prev_count[w];
			delta = wide_t'($signed(du));
			if (rev)
				delta = -delta;
			mag = (delta < 0) ? -delta : delta;
			cpr_eff = (cfg.counts_per_rev == 16'd0) ? 16'd1 : cfg.counts_per_rev;
			den = {48'd0, cpr_eff} * {48'd0, ms};
			q = (mag * 128'sd3932160000) / $signed({64'd0, den});
			if (delta < 0)
				spd = (q >= 128'sd2147483648) ? 32'sh8000_0000 : -q[31:0];
			else
				spd = (q > I32_MAX) ? 32'sh7FFF_FFFF : q[31:0];
		end
		prev_count[w] = cnt;

		err = wide_t'(cfg.target_speed) - wide_t'(spd);
		err = clip(err, I32_MIN, I32_MAX);
		deriv = err - wide_t'(prev_err[w]);
		sum = wide_t'(err_acc[w]) + err;
		sum = clip(clip(sum, -SAT, SAT), SUM_MIN, SUM_MAX);
		err_acc[w] = sum[63:0];
		prev_err[w] = err[31:0];

		acc = clip(scale_gain(err, cfg.gain_p) + scale_gain(sum, cfg.gain_i), -SAT, SAT);
		acc = clip(acc + scale_gain(deriv, cfg.gain_d), -SAT, SAT);

		r.wheel = w;
		r.speed = spd;
		r.time_err = (ms == 16'd0);
		if (acc < 0) begin
			r.drive = 16'd0;
			r.clamped = 1'b1;
		end else begin
			q = acc >>> 24;
			if (q > $signed({112'd0, cfg.pwm_max})) begin
				r.drive = cfg.pwm_max;
				r.clamped = 1'b1;
			end else begin
				r.drive = q[15:0];
				r.clamped = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		wheel_result_t want_r;
		wheel_result_t got_r;
		if (!arst_n) begin
			cfg.target_speed   = RST_TARGET;
			cfg.gain_p         = RST_GAIN_P;
			cfg.gain_i         = RST_GAIN_I;
			cfg.gain_d         = RST_GAIN_D;
			cfg.counts_per_rev = RST_CPR;
			cfg.pwm_max        = RST_PWM_MAX;
			for (int k = 0; k < NW; k++) begin
				prev_count[k] = '0;
				prev_err[k]   = '0;
				err_acc[k]    = '0;
			end
			wheel_results.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_TARGET:  cfg.target_speed   = pwdata[31:0];
					REG_GAIN_P:  cfg.gain_p         = pwdata[15:0];
					REG_GAIN_I:  cfg.gain_i         = pwdata[15:0];
					REG_GAIN_D:  cfg.gain_d         = pwdata[15:0];
					REG_CPR:     cfg.counts_per_rev = pwdata[15:0];
					REG_PWM_MAX: cfg.pwm_max        = pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready && (int'(s_tuser[1:0]) < NW))
				wheel_results.push_back(pid_step(s_tuser[1:0], s_tdata[31:0],
					s_tdata[47:32], s_tuser[2]));
			if (m_tvalid && m_tready) begin
				got_r.wheel    = m_tuser[1:0];
				got_r.speed    = m_tdata[31:0];
				got_r.drive    = m_tdata[47:32];
				got_r.clamped  = m_tuser[2];
				got_r.time_err = m_tuser[3];
				if (wheel_results.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, got_r);
					fail_count++;
				end else begin
					want_r = wheel_results.pop_front();
					check_field("wheel_out", 32'(want_r.wheel), 32'(got_r.wheel));
					check_field("speed", want_r.speed, got_r.speed);
					check_field("drive", 32'(want_r.drive), 32'(got_r.drive));
					check_field("clamped", 32'(want_r.clamped), 32'(got_r.clamped));
					check_field("time_error", 32'(want_r.time_err), 32'(got_r.time_err));
				end
			end
			outstanding = wheel_results.size();
		end
	end

endmodule

// ===== bench/tb_encoder_speed_pid_top.sv =====
module tb_encoder_speed_pid_top;
	import esp_pkg::*;

	localparam int LIMIT       = 1_500_000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 225;
	localparam int HOLD_START  = 30000;
	localparam int HOLD_LEN    = 800;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;  // count[31:0], elapsed_ms[47:32]
	logic [2:0]            s_tuser;  // wheel[1:0], reversed[2]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [47:0]           m_tdata;  // speed[31:0], drive[47:32]
	logic [3:0]            m_tuser;  // wheel_out[1:0], clamped[2], time_error[3]
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    outstanding;

	int          cyc = 0;
	logic        quiet;
	logic [31:0] track [4];

	assign quiet = (cyc >= 45000) && (cyc < 75000);

	encoder_speed_pid_top u_top (.*);

	speed_pid_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int rx_cyc;
		rx_cyc = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN)
				m_tready <= 1'b0;
			else if (quiet)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 6);
		end
	end

	task automatic offer_sample(input logic [1:0] w, input logic [31:0] cnt,
			input logic [15:0] ms, input logic rev);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 6) begin
			gap = $urandom_range(1, 70);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ms, cnt};
		s_tuser  <= {rev, w};
		track[w] = cnt;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic apply_setting(input int ph);
		case (ph)
			1: begin
				reg_write(REG_TARGET, 32'h7FFF_FFFF);
				reg_write(REG_GAIN_P, 32'hFFFF);
				reg_write(REG_GAIN_I, 32'hFFFF);
				reg_write(REG_GAIN_D, 32'hFFFF);
				reg_write(REG_CPR, 32'hFFFF);
				reg_write(REG_PWM_MAX, 32'hFFFF);
			end
			2: begin
				reg_write(REG_TARGET, 32'h8000_0000);
				reg_write(REG_GAIN_P, 32'd0);
				reg_write(REG_GAIN_I, 32'd0);
				reg_write(REG_GAIN_D, 32'd0);
				reg_write(REG_CPR, 32'd1);
				reg_write(REG_PWM_MAX, 32'd0);
			end
			default: begin
				reg_write(REG_TARGET, $urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
				reg_write(REG_GAIN_P, $urandom_range(0, 65535));
				reg_write(REG_GAIN_I, $urandom_range(0, 65535));
				reg_write(REG_GAIN_D, $urandom_range(0, 65535));
				reg_write(REG_CPR, (ph == 3) ? 32'd0 : $urandom_range(1, 4096));
				reg_write(REG_PWM_MAX, $urandom_range(0, 65535));
			end
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int          r;
		int          k;
		logic [1:0]  w;
		logic [31:0] cnt;
		logic [31:0] d;
		logic [15:0] ms;
		logic        rev;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (int i = 0; i < 4; i++)
			track[i] = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_sample(2'd0, 32'd1000, 16'd10, 1'b0);
		offer_sample(2'd0, 32'd0, 16'd10, 1'b0);
		offer_sample(2'd1, 32'd12345, 16'd0, 1'b0);
		offer_sample(2'd1, 32'd12400, 16'd0, 1'b1);
		offer_sample(2'd2, 32'h8000_0000, 16'd1, 1'b0);
		offer_sample(2'd2, 32'h0000_0000, 16'd1, 1'b1);
		offer_sample(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		offer_sample(2'd3, 32'hFFFF_FFFF, 16'd1, 1'b0);
		offer_sample(2'd0, 32'h7FFF_FFFF, 16'd1, 1'b0);
		offer_sample(2'd0, 32'h8000_0063, 16'hFFFF, 1'b1);
		offer_sample(2'd1, 32'd12450, 16'd20, 1'b0);
		offer_sample(2'd2, 32'hFFFF_0000, 16'd3, 1'b1);
		offer_sample(2'd3, 32'hFFFF_FF00, 16'h8000, 1'b0);
		offer_sample(2'd1, 32'd12450, 16'd7, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain();
				apply_setting(ph);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				w = 2'($urandom_range(0, 3));
				rev = 1'($urandom_range(0, 1));
				k = $urandom_range(0, 16);
				d = $urandom_range(0, 1 << k);
				cnt = $urandom_range(0, 1) ? track[w] + d : track[w] - d;
				ms = 16'($urandom_range(1, 200));
				if (r >= 80 && r < 86) begin
					ms = 16'd0;
				end else if (r >= 86 && r < 94) begin
					cnt = $urandom;
					ms = 16'($urandom);
				end else if (r >= 94) begin
					ms = 16'($urandom_range(1000, 65535));
				end
				offer_sample(w, cnt, ms, rev);
			end
		end

		drain();
		repeat (60) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
